/* rtl/core/cmvs4_pkg.sv */
// shared types and constants for the complex matrix-vector sum core
package cmvs4_pkg;

    // accumulator, fraction and result widths
    localparam int ACC_W  = 42;
    localparam int FRAC_W = 15;
    localparam int OUT_W  = 24;
    localparam int SHR_W  = ACC_W - FRAC_W;
    localparam int ROWS   = 3;

    typedef logic signed [ACC_W-1:0] t_acc;
    typedef logic signed [OUT_W-1:0] t_out;
    typedef logic signed [SHR_W-1:0] t_shr;

endpackage

/* rtl/core/cmvs4_if.sv */
// stream interfaces for the column input and the result output

interface cmvs4_in_if #(
    parameter int SAMPLE_WIDTH = 18
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] col_row0_re;
    logic signed [SAMPLE_WIDTH-1:0] col_row0_im;
    logic signed [SAMPLE_WIDTH-1:0] col_row1_re;
    logic signed [SAMPLE_WIDTH-1:0] col_row1_im;
    logic signed [SAMPLE_WIDTH-1:0] col_row2_re;
    logic signed [SAMPLE_WIDTH-1:0] col_row2_im;
    logic signed [SAMPLE_WIDTH-1:0] vec_re;
    logic signed [SAMPLE_WIDTH-1:0] vec_im;
    logic                           last_term;

    modport source (
        output valid, col_row0_re, col_row0_im, col_row1_re, col_row1_im,
               col_row2_re, col_row2_im, vec_re, vec_im, last_term,
        input  ready
    );
    modport sink (
        input  valid, col_row0_re, col_row0_im, col_row1_re, col_row1_im,
               col_row2_re, col_row2_im, vec_re, vec_im, last_term,
        output ready
    );
endinterface

interface cmvs4_out_if;
    import cmvs4_pkg::*;

    logic valid;
    logic ready;
    t_out sum0_re;
    t_out sum0_im;
    t_out sum1_re;
    t_out sum1_im;
    t_out sum2_re;
    t_out sum2_im;
    logic clipped;

    modport source (
        output valid, sum0_re, sum0_im, sum1_re, sum1_im, sum2_re, sum2_im, clipped,
        input  ready
    );
    modport sink (
        input  valid, sum0_re, sum0_im, sum1_re, sum1_im, sum2_re, sum2_im, clipped,
        output ready
    );
endinterface

/* rtl/core/complex_mat_vec_sum_four_core.sv */
// complex 3x3 matrix times vector, accumulated over directions, saturated output
//
// Each transfer on i_in carries one matrix column and the matching vector component;
// the core takes one column every clock cycle unless o_out back-pressure stalls it,
// using twelve parallel SAMPLE_WIDTH x SAMPLE_WIDTH multipliers feeding six 42-bit
// wrapping accumulators. The sum closes on the column flagged last_term; its result
// then appears on o_out and the accumulators restart from zero for the next sum.
// Results are floor(acc / 2^15) saturated to 24 bits, with clipped set if any
// component saturated. The pipeline is input register, product register, accumulate,
// finish register and output register; all but the accumulate stage have their own
// valid bit, so a result waiting on o_out does not hold up columns of the next sum.
module complex_mat_vec_sum_four_core #(
    parameter int SAMPLE_WIDTH = 18
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cmvs4_in_if.sink    i_in,
    cmvs4_out_if.source o_out
);
    import cmvs4_pkg::*;

    localparam int PW = 2 * SAMPLE_WIDTH;

    typedef logic signed [SAMPLE_WIDTH-1:0] t_smp;
    typedef logic signed [PW-1:0]           t_prod;

    // pipeline valid bits
    logic r_s1_valid, n_s1_valid;
    logic r_s2_valid, n_s2_valid;
    logic r_fin_valid, n_fin_valid;
    logic r_out_valid, n_out_valid;

    // stage payloads
    t_smp  r_s1_a_re [ROWS];
    t_smp  r_s1_a_im [ROWS];
    t_smp  r_s1_b_re;
    t_smp  r_s1_b_im;
    logic  r_s1_last;
    t_prod r_s2_p_rr [ROWS];
    t_prod r_s2_p_ii [ROWS];
    t_prod r_s2_p_ri [ROWS];
    t_prod r_s2_p_ir [ROWS];
    logic  r_s2_last;
    t_acc  r_acc_re  [ROWS];
    t_acc  r_acc_im  [ROWS];
    t_acc  n_acc_re  [ROWS];
    t_acc  n_acc_im  [ROWS];
    t_acc  r_fin_re  [ROWS];
    t_acc  r_fin_im  [ROWS];
    t_out  r_out_re  [ROWS];
    t_out  r_out_im  [ROWS];
    logic  r_out_clip;

    // finish results
    t_out  n_out_re  [ROWS];
    t_out  n_out_im  [ROWS];
    logic  n_out_clip;

    // flow control
    logic in_xfer, out_free, fin_move, fin_free, s2_fire, s2_free, s1_free;

    // stage handshakes, each stage advances when the one after it has room
    always_comb begin
        out_free    = !r_out_valid || o_out.ready;
        fin_move    = r_fin_valid && out_free;
        fin_free    = !r_fin_valid || out_free;
        s2_fire     = r_s2_valid && (!r_s2_last || fin_free);
        s2_free     = !r_s2_valid || s2_fire;
        s1_free     = !r_s1_valid || s2_free;
        in_xfer     = i_in.valid && s1_free;
        n_s1_valid  = (r_s1_valid && !s2_free) || in_xfer;
        n_s2_valid  = (r_s2_valid && !s2_fire) || (r_s1_valid && s2_free);
        n_fin_valid = (r_fin_valid && !fin_move) || (s2_fire && r_s2_last);
        n_out_valid = fin_move || (r_out_valid && !o_out.ready);
    end

    assign i_in.ready = s1_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_fin_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_s2_valid  <= n_s2_valid;
            r_fin_valid <= n_fin_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_a_re[0] <= i_in.col_row0_re;
            r_s1_a_im[0] <= i_in.col_row0_im;
            r_s1_a_re[1] <= i_in.col_row1_re;
            r_s1_a_im[1] <= i_in.col_row1_im;
            r_s1_a_re[2] <= i_in.col_row2_re;
            r_s1_a_im[2] <= i_in.col_row2_im;
            r_s1_b_re    <= i_in.vec_re;
            r_s1_b_im    <= i_in.vec_im;
            r_s1_last    <= i_in.last_term;
        end
    end

    // product register, four real products per row
    always_ff @(posedge i_clk) begin
        if (r_s1_valid && s2_free) begin
            for (int i = 0; i < ROWS; i++) begin
                r_s2_p_rr[i] <= r_s1_a_re[i] * r_s1_b_re;
                r_s2_p_ii[i] <= r_s1_a_im[i] * r_s1_b_im;
                r_s2_p_ri[i] <= r_s1_a_re[i] * r_s1_b_im;
                r_s2_p_ir[i] <= r_s1_a_im[i] * r_s1_b_re;
            end
            r_s2_last <= r_s1_last;
        end
    end

    // complex accumulate, wrapping at the accumulator width
    always_comb begin
        for (int i = 0; i < ROWS; i++) begin
            n_acc_re[i] = r_acc_re[i] + ACC_W'(r_s2_p_rr[i]) - ACC_W'(r_s2_p_ii[i]);
            n_acc_im[i] = r_acc_im[i] + ACC_W'(r_s2_p_ri[i]) + ACC_W'(r_s2_p_ir[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ROWS; i++) begin
                r_acc_re[i] <= '0;
                r_acc_im[i] <= '0;
            end
        end else if (s2_fire) begin
            for (int i = 0; i < ROWS; i++) begin
                r_acc_re[i] <= r_s2_last ? '0 : n_acc_re[i];
                r_acc_im[i] <= r_s2_last ? '0 : n_acc_im[i];
            end
        end
    end

    // finish register holds the closed sum
    always_ff @(posedge i_clk) begin
        if (s2_fire && r_s2_last) begin
            for (int i = 0; i < ROWS; i++) begin
                r_fin_re[i] <= n_acc_re[i];
                r_fin_im[i] <= n_acc_im[i];
            end
        end
    end

    // floor shift and saturate to the output width
    function automatic t_out sat_out(input t_acc x, output logic clip);
        t_shr q;
        q    = t_shr'(x >>> FRAC_W);
        clip = (q[SHR_W-1:OUT_W-1] != '0) && (q[SHR_W-1:OUT_W-1] != '1);
        if (!clip) begin
            sat_out = q[OUT_W-1:0];
        end else if (q[SHR_W-1]) begin
            sat_out = {1'b1, {(OUT_W-1){1'b0}}};
        end else begin
            sat_out = {1'b0, {(OUT_W-1){1'b1}}};
        end
    endfunction

    always_comb begin
        logic c_re [ROWS];
        logic c_im [ROWS];
        n_out_clip = 1'b0;
        for (int i = 0; i < ROWS; i++) begin
            n_out_re[i] = sat_out(r_fin_re[i], c_re[i]);
            n_out_im[i] = sat_out(r_fin_im[i], c_im[i]);
            n_out_clip  = n_out_clip | c_re[i] | c_im[i];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (fin_move) begin
            for (int i = 0; i < ROWS; i++) begin
                r_out_re[i] <= n_out_re[i];
                r_out_im[i] <= n_out_im[i];
            end
            r_out_clip <= n_out_clip;
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.sum0_re = r_out_re[0];
    assign o_out.sum0_im = r_out_im[0];
    assign o_out.sum1_re = r_out_re[1];
    assign o_out.sum1_im = r_out_im[1];
    assign o_out.sum2_re = r_out_re[2];
    assign o_out.sum2_im = r_out_im[2];
    assign o_out.clipped = r_out_clip;

endmodule

/* tb/sv/cmvs4_sum_checker.sv */
// scoreboard for the complex matrix-vector sum core: predicts every sum and checks the results
module cmvs4_sum_checker
    import cmvs4_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    cmvs4_in_if  i_col,
    cmvs4_out_if i_res,
    output int   o_mismatches,
    output int   o_pending,
    output int   o_sums_checked,
    output int   o_saturated
);

    localparam longint OUT_HI       = (longint'(1) <<< (OUT_W - 1)) - 1;
    localparam longint OUT_LO       = -(longint'(1) <<< (OUT_W - 1));
    localparam int     REPORT_LIMIT = 10;

    // one finished sum: re/im of rows 0..2 in order, then the saturation flag
    typedef struct packed {
        t_out [2*ROWS-1:0] comp;
        logic              clipped;
    } t_sum_result;

    string field_name [2*ROWS] = '{"sum0_re", "sum0_im", "sum1_re", "sum1_im",
                                   "sum2_re", "sum2_im"};

    t_acc        row_acc [2*ROWS];
    t_sum_result sums_due [$];
    int          mismatches = 0;
    int          checked    = 0;
    int          saturated  = 0;

    // floor to the output format, then clamp to 24 bits
    function automatic t_out floor_saturate(input t_acc a, output logic sat);
        t_shr q;
        q   = t_shr'(a >>> FRAC_W);
        sat = 1'b0;
        if (longint'(q) > OUT_HI) begin
            sat = 1'b1;
            return t_out'(OUT_HI);
        end
        if (longint'(q) < OUT_LO) begin
            sat = 1'b1;
            return t_out'(OUT_LO);
        end
        return t_out'(q);
    endfunction

    task automatic flag_mismatch(input string msg);
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
    endtask

    // watch both channels at each rising edge
    always @(posedge i_clk) begin : watch
        t_sum_result seen;
        t_sum_result want;
        longint      mat [2*ROWS];
        longint      vre;
        longint      vim;
        longint      prod_re;
        longint      prod_im;
        logic        sat;
        logic        clip;

        if (!i_rst_n) begin
            for (int k = 0; k < 2*ROWS; k++) row_acc[k] = '0;
            sums_due.delete();
            mismatches = 0;
            checked    = 0;
            saturated  = 0;
        end else begin
            // result transfer: compare against the oldest finished sum
            if (i_res.valid && i_res.ready) begin
                seen.comp[0] = i_res.sum0_re;
                seen.comp[1] = i_res.sum0_im;
                seen.comp[2] = i_res.sum1_re;
                seen.comp[3] = i_res.sum1_im;
                seen.comp[4] = i_res.sum2_re;
                seen.comp[5] = i_res.sum2_im;
                seen.clipped = i_res.clipped;
                if (sums_due.size() == 0) begin
                    flag_mismatch($sformatf("result with no sum closed (sum0_re %0d)",
                                            seen.comp[0]));
                end else begin
                    want = sums_due.pop_front();
                    for (int k = 0; k < 2*ROWS; k++) begin
                        if (seen.comp[k] !== want.comp[k]) begin
                            flag_mismatch($sformatf("sum %0d %s: expected %0d, got %0d",
                                                    checked, field_name[k],
                                                    want.comp[k], seen.comp[k]));
                        end
                    end
                    if (seen.clipped !== want.clipped) begin
                        flag_mismatch($sformatf("sum %0d clipped: expected %0b, got %0b",
                                                checked, want.clipped, seen.clipped));
                    end
                end
                checked++;
            end

            // column transfer: one complex multiply-accumulate per row
            if (i_col.valid && i_col.ready) begin
                mat[0] = i_col.col_row0_re;
                mat[1] = i_col.col_row0_im;
                mat[2] = i_col.col_row1_re;
                mat[3] = i_col.col_row1_im;
                mat[4] = i_col.col_row2_re;
                mat[5] = i_col.col_row2_im;
                vre    = i_col.vec_re;
                vim    = i_col.vec_im;
                for (int r = 0; r < ROWS; r++) begin
                    prod_re = mat[2*r] * vre - mat[2*r+1] * vim;
                    prod_im = mat[2*r] * vim + mat[2*r+1] * vre;
                    row_acc[2*r]   = row_acc[2*r] + t_acc'(prod_re);
                    row_acc[2*r+1] = row_acc[2*r+1] + t_acc'(prod_im);
                end
                // last column closes the sum and clears the accumulators
                if (i_col.last_term) begin
                    clip = 1'b0;
                    for (int k = 0; k < 2*ROWS; k++) begin
                        want.comp[k] = floor_saturate(row_acc[k], sat);
                        clip         = clip | sat;
                        row_acc[k]   = '0;
                    end
                    want.clipped = clip;
                    if (clip) saturated++;
                    sums_due.push_back(want);
                end
            end
        end

        o_mismatches   <= mismatches;
        o_pending      <= sums_due.size();
        o_sums_checked <= checked;
        o_saturated    <= saturated;
    end

endmodule

/* tb/sv/tb_complex_mat_vec_sum_four_core.sv */
// testbench top for the complex matrix-vector sum core: clock, reset, stimulus and verdict
module tb_complex_mat_vec_sum_four_core;
    import cmvs4_pkg::*;

    localparam int SW             = 18;
    localparam int TARGET_COLUMNS = 850;
    localparam int DRAIN_CYCLES   = 12;

    typedef logic signed [SW-1:0] t_sample;

    localparam t_sample S_MAX = t_sample'(131071);
    localparam t_sample S_MIN = t_sample'(-131072);

    typedef enum int {SUM_PLAIN, SUM_ODD_LEN, SUM_HOT, SUM_WRAP, SUM_TINY} t_sum_kind;

    typedef struct {
        t_sample mat [2*ROWS];
        t_sample vec_re;
        t_sample vec_im;
        logic    last_term;
    } t_column;

    logic clk = 1'b0;
    logic rst_n;
    int   columns_sent = 0;
    int   sums_sent    = 0;
    int   mismatches;
    int   pending;
    int   sums_checked;
    int   saturated;

    cmvs4_in_if #(.SAMPLE_WIDTH(SW)) col_ch ();
    cmvs4_out_if                     sum_ch ();

    complex_mat_vec_sum_four_core #(.SAMPLE_WIDTH(SW)) dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (col_ch),
        .o_out   (sum_ch)
    );

    cmvs4_sum_checker checker_inst (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_col          (col_ch),
        .i_res          (sum_ch),
        .o_mismatches   (mismatches),
        .o_pending      (pending),
        .o_sums_checked (sums_checked),
        .o_saturated    (saturated)
    );

    // clock
    always #10 clk = ~clk;

    // idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // one matrix or vector entry for the given kind of sum
    function automatic t_sample pick_sample(input t_sum_kind kind, input t_sample base);
        int r;
        case (kind)
            SUM_HOT, SUM_WRAP: return base ^ t_sample'($urandom_range(0, 255));
            SUM_TINY:          return t_sample'(int'($urandom_range(0, 31)) - 16);
            default: begin
                r = $urandom_range(0, 9);
                if (r == 0) return S_MAX;
                if (r == 1) return S_MIN;
                if (r == 2) return t_sample'(int'($urandom_range(0, 31)) - 16);
                return t_sample'($urandom);
            end
        endcase
    endfunction

    // present one column and hold it until the transfer
    task automatic drive_column(input t_column c, input bit calm);
        int gap;
        gap = calm ? 0 : pick_gap();
        @(negedge clk);
        if (gap > 0) begin
            col_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        col_ch.col_row0_re <= c.mat[0];
        col_ch.col_row0_im <= c.mat[1];
        col_ch.col_row1_re <= c.mat[2];
        col_ch.col_row1_im <= c.mat[3];
        col_ch.col_row2_re <= c.mat[4];
        col_ch.col_row2_im <= c.mat[5];
        col_ch.vec_re      <= c.vec_re;
        col_ch.vec_im      <= c.vec_im;
        col_ch.last_term   <= c.last_term;
        col_ch.valid       <= 1'b1;
        do @(posedge clk); while (!col_ch.ready);
        columns_sent++;
        if (c.last_term) sums_sent++;
    endtask

    // n identical columns, every row the same entry, last one closes the sum
    task automatic send_uniform(input t_sample mre, input t_sample mim,
                                input t_sample vre, input t_sample vim, input int n);
        t_column c;
        for (int r = 0; r < ROWS; r++) begin
            c.mat[2*r]   = mre;
            c.mat[2*r+1] = mim;
        end
        c.vec_re = vre;
        c.vec_im = vim;
        for (int i = 0; i < n; i++) begin
            c.last_term = (i == n - 1);
            drive_column(c, 1'b0);
        end
    endtask

    // one random sum; hot and wrap sums keep near one extreme column so they add up
    task automatic send_sum(input t_sum_kind kind, input int len, input bit calm);
        t_column base;
        t_column c;
        for (int k = 0; k < 2*ROWS; k++) base.mat[k] = $urandom_range(0, 1) ? S_MAX : S_MIN;
        base.vec_re = $urandom_range(0, 1) ? S_MAX : S_MIN;
        base.vec_im = $urandom_range(0, 1) ? S_MAX : S_MIN;
        for (int n = 0; n < len; n++) begin
            for (int k = 0; k < 2*ROWS; k++) c.mat[k] = pick_sample(kind, base.mat[k]);
            c.vec_re    = pick_sample(kind, base.vec_re);
            c.vec_im    = pick_sample(kind, base.vec_im);
            c.last_term = (n == len - 1);
            drive_column(c, calm);
        end
    endtask

    // result side: ready runs and stalls of random length
    initial begin : sink_side
        int hold;
        int stall;
        sum_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            hold  = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 8);
            stall = pick_gap();
            @(negedge clk);
            sum_ch.ready <= 1'b1;
            repeat (hold - 1) @(negedge clk);
            if (stall > 0) begin
                @(negedge clk);
                sum_ch.ready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
        end
    end

    // stimulus and verdict
    initial begin : stimulus
        t_column   c;
        t_sum_kind kind;
        int        len;
        int        r;

        rst_n              = 1'b0;
        col_ch.valid       = 1'b0;
        col_ch.col_row0_re = '0;
        col_ch.col_row0_im = '0;
        col_ch.col_row1_re = '0;
        col_ch.col_row1_im = '0;
        col_ch.col_row2_re = '0;
        col_ch.col_row2_im = '0;
        col_ch.vec_re      = '0;
        col_ch.vec_im      = '0;
        col_ch.last_term   = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // positive saturation on the imaginary parts
        send_uniform(S_MAX, S_MAX, S_MAX, S_MAX, 9);
        // negative saturation on the real parts
        send_uniform(S_MAX, S_MIN, S_MIN, S_MIN, 9);
        // single-column sum of the most negative values
        send_uniform(S_MIN, S_MIN, S_MIN, S_MIN, 1);
        // floor rounding just below zero, differing rows
        for (int k = 0; k < 2*ROWS; k++) c.mat[k] = '0;
        c.mat[0]    = t_sample'(1);
        c.mat[2]    = t_sample'(-1);
        c.mat[5]    = S_MAX;
        c.vec_re    = t_sample'(-1);
        c.vec_im    = '0;
        c.last_term = 1'b1;
        drive_column(c, 1'b0);
        // all-zero single column
        send_uniform('0, '0, '0, '0, 1);

        // random sums, some far past the nominal length so the accumulators wrap
        while (columns_sent < TARGET_COLUMNS) begin
            r = $urandom_range(0, 99);
            if (r < 50) begin
                kind = SUM_PLAIN;
                len  = 12;
            end else if (r < 70) begin
                kind = SUM_ODD_LEN;
                len  = $urandom_range(1, 24);
            end else if (r < 85) begin
                kind = SUM_HOT;
                len  = 12;
            end else if (r < 88) begin
                kind = SUM_WRAP;
                len  = $urandom_range(66, 90);
            end else begin
                kind = SUM_TINY;
                len  = $urandom_range(1, 12);
            end
            send_sum(kind, len, $urandom_range(0, 4) == 0);
        end
        @(negedge clk);
        col_ch.valid <= 1'b0;

        // drain
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d columns in %0d sums, including wrapping and single-column sums",
                 columns_sent, sums_sent);
        $display("%0d results checked, %0d saturated, %0d mismatches",
                 sums_checked, saturated, mismatches);
        if (mismatches == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // run limit
    initial begin : watchdog
        #10_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
